[src/opcode_site_locator_unit_assert.svh]
// assertion macros for the opcode site locator
// no dependencies; included by the files that hold concurrent assertions
`ifndef OPCODE_SITE_LOCATOR_UNIT_ASSERT_SVH
`define OPCODE_SITE_LOCATOR_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define OSL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("opcode site locator check failed");
`define OSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("opcode site locator check failed");
`else
`define OSL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define OSL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/osl_pkg.sv]
// types and constants of the opcode site locator
// no dependencies; imported by the top level
`timescale 1ns / 1ps
package osl_pkg;

    localparam int TABLE_DEPTH   = 1024;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
    localparam int COVER_INDEX_W = 10;
    localparam int ADDR_W        = 64;
    localparam int PADDR_W       = 4;

    localparam logic [7:0] PAIR_FIRST  = 8'h0F;
    localparam logic [7:0] PAIR_SECOND = 8'h05;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_BYTE = 1'b1;

    localparam logic REG_BASE_ADDRESS = 1'b0;
    localparam logic REG_FILE_OFFSET  = 1'b1;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] interval_start;
        logic [ADDR_W-1:0] interval_size;
        logic              is_function;
        logic [7:0]        code_byte;
        logic              last_byte;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]        hit_address;
        logic [ADDR_W-1:0]        hit_file_offset;
        logic                     covered;
        logic [COVER_INDEX_W-1:0] cover_index;
        logic [ADDR_W-1:0]        cover_start;
        logic [ADDR_W-1:0]        cover_size;
    } out_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_RD,
        ST_LOAD_CMP,
        ST_SRCH_SETUP,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_CHK,
        ST_DONE
    } state_t;

endpackage

[src/opcode_site_locator_unit.sv]
// top level of the opcode site locator: apb registers, sequencer, result register
// depends on osl_pkg, osl_ram and opcode_site_locator_unit_assert.svh
// byte transfer: a completed pair starts a binary search over the n table entries, then a cover
// check, then a wait for the result register; no new transfer is taken until the result is written
// load transfer: unless dropped, later entries move up one place each until the new one is placed
// reset: control state, counters and registers clear at once; table contents undefined
`timescale 1ns / 1ps
`include "opcode_site_locator_unit_assert.svh"
module opcode_site_locator_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  osl_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output osl_pkg::out_item_t                out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [osl_pkg::PADDR_W-1:0]       paddr,
    input  logic [osl_pkg::ADDR_W-1:0]        pwdata,
    output logic [osl_pkg::ADDR_W-1:0]        prdata,
    output logic                              pready
);
    import osl_pkg::*;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] base_reg, fofs_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] bpos_reg, bpos_next;
    logic [7:0]        prev_reg, prev_next;
    logic              pv_reg, pv_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [CNT_W-1:0]  mid_reg, mid_next;
    entry_t            new_reg, new_next;
    logic [ADDR_W-1:0] rel_reg, rel_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] hofs_reg, hofs_next;
    logic              cov_reg, cov_next;
    logic [IDX_W-1:0]  cidx_reg, cidx_next;
    entry_t            cent_reg, cent_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr, mem_raddr;
    entry_t            mem_wdata, mem_rdata;
    logic              in_accept, cfg_write;

    function automatic logic goes_before(entry_t cur, entry_t ins);
        if (cur.start != ins.start)
        begin
            return cur.start < ins.start;
        end
        return cur.size >= ins.size;
    endfunction

    osl_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[3] == REG_FILE_OFFSET) ? fofs_reg : base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            fofs_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3])
                REG_BASE_ADDRESS: base_reg <= pwdata;
                REG_FILE_OFFSET:  fofs_reg <= pwdata;
                default:          base_reg <= base_reg;
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            bpos_reg      <= '0;
            prev_reg      <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            bpos_reg      <= bpos_next;
            prev_reg      <= prev_next;
            pv_reg        <= pv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        new_reg  <= new_next;
        rel_reg  <= rel_next;
        addr_reg <= addr_next;
        hofs_reg <= hofs_next;
        cov_reg  <= cov_next;
        cidx_reg <= cidx_next;
        cent_reg <= cent_next;
        out_reg  <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        bpos_next      = bpos_reg;
        prev_next      = prev_reg;
        pv_next        = pv_reg;
        pos_next       = pos_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        new_next       = new_reg;
        rel_next       = rel_reg;
        addr_next      = addr_reg;
        hofs_next      = hofs_reg;
        cov_next       = cov_reg;
        cidx_next      = cidx_reg;
        cent_next      = cent_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg[IDX_W-1:0];
        mem_wdata      = mem_rdata;
        mem_raddr      = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && in_data.op == OP_LOAD)
                begin
                    new_next.start = in_data.interval_start;
                    new_next.size  = in_data.interval_size;
                    pos_next       = count_reg;
                    if (in_data.is_function && in_data.interval_size != '0 &&
                        in_data.interval_start != '0 && count_reg < CNT_W'(TABLE_DEPTH))
                    begin
                        state_next = ST_LOAD_RD;
                    end
                end
                else if (in_accept)
                begin
                    rel_next = bpos_reg - ADDR_W'(1);
                    if (pv_reg && prev_reg == PAIR_FIRST && in_data.code_byte == PAIR_SECOND)
                    begin
                        state_next = ST_SRCH_SETUP;
                    end
                    if (in_data.last_byte)
                    begin
                        bpos_next = '0;
                        prev_next = '0;
                        pv_next   = 1'b0;
                    end
                    else
                    begin
                        bpos_next = bpos_reg + ADDR_W'(1);
                        prev_next = in_data.code_byte;
                        pv_next   = 1'b1;
                    end
                end
            end
            ST_LOAD_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = '0;
                    mem_wdata  = new_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_raddr  = IDX_W'(pos_reg - CNT_W'(1));
                    state_next = ST_LOAD_CMP;
                end
            end
            ST_LOAD_CMP:
            begin
                mem_we = 1'b1;
                if (goes_before(mem_rdata, new_reg))
                begin
                    mem_wdata  = new_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_wdata  = mem_rdata;
                    pos_next   = pos_reg - CNT_W'(1);
                    state_next = ST_LOAD_RD;
                end
            end
            ST_SRCH_SETUP:
            begin
                addr_next  = base_reg + rel_reg;
                hofs_next  = fofs_reg + rel_reg;
                lo_next    = '0;
                hi_next    = count_reg;
                state_next = ST_SRCH_RD;
            end
            ST_SRCH_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = lo_reg + ((hi_reg - lo_reg) >> 1);
                    mem_raddr  = IDX_W'(lo_reg + ((hi_reg - lo_reg) >> 1));
                    state_next = ST_SRCH_CMP;
                end
                else if (lo_reg == '0)
                begin
                    cov_next   = 1'b0;
                    cidx_next  = '0;
                    cent_next  = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_raddr  = IDX_W'(lo_reg - CNT_W'(1));
                    cidx_next  = IDX_W'(lo_reg - CNT_W'(1));
                    state_next = ST_CHK;
                end
            end
            ST_SRCH_CMP:
            begin
                if (mem_rdata.start <= addr_reg)
                begin
                    lo_next = mid_reg + CNT_W'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = ST_SRCH_RD;
            end
            ST_CHK:
            begin
                if (addr_reg >= mem_rdata.start &&
                    (addr_reg - mem_rdata.start) < mem_rdata.size)
                begin
                    cov_next  = 1'b1;
                    cent_next = mem_rdata;
                end
                else
                begin
                    cov_next  = 1'b0;
                    cidx_next = '0;
                    cent_next = '0;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next           = 1'b1;
                    out_next.hit_address     = addr_reg;
                    out_next.hit_file_offset = hofs_reg;
                    out_next.covered         = cov_reg;
                    out_next.cover_index     = COVER_INDEX_W'(cidx_reg);
                    out_next.cover_start     = cent_reg.start;
                    out_next.cover_size      = cent_reg.size;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `OSL_ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH))
    `OSL_ASSERT_NEXT(a_full_load_dropped, clk, rst_n,
        in_accept && in_data.op == OP_LOAD && count_reg == CNT_W'(TABLE_DEPTH),
        $stable(count_reg))
    `OSL_ASSERT_IMPLIES(a_search_bounds, clk, rst_n, state_reg == ST_SRCH_RD,
        lo_reg <= hi_reg && hi_reg <= count_reg)
    `OSL_ASSERT_IMPLIES(a_cover_below_hit, clk, rst_n, out_valid_reg && out_reg.covered,
        out_reg.cover_start <= out_reg.hit_address)
    `OSL_ASSERT_NEXT(a_done_waits, clk, rst_n,
        state_reg == ST_DONE && out_valid_reg && !out_ready, state_reg == ST_DONE)

endmodule

[src/osl_ram.sv]
// generic simple dual-port ram with registered read
// no dependencies; holds the sorted interval table
`timescale 1ns / 1ps
module osl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[test/site_hit_checker.sv]
// checker for the opcode site locator: watches the register port and both channels,
// keeps its own copy of the interval table and byte tracking, and compares every result
// depends on osl_pkg
`timescale 1ns / 1ps
module site_hit_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  osl_pkg::in_item_t            in_data,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  osl_pkg::out_item_t           out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [osl_pkg::PADDR_W-1:0]  paddr,
    input  logic [osl_pkg::ADDR_W-1:0]   pwdata,
    input  logic                         pready,
    output int                           fail_count,
    output int                           pending,
    output int                           result_count
);
    import osl_pkg::*;

    logic [ADDR_W-1:0] base_address = '0;
    logic [ADDR_W-1:0] file_offset = '0;
    logic [ADDR_W-1:0] start_tab [TABLE_DEPTH];
    logic [ADDR_W-1:0] size_tab [TABLE_DEPTH];
    int                entry_total = 0;
    logic [ADDR_W-1:0] stream_pos = '0;
    logic [7:0]        last_seen = '0;
    logic              last_seen_ok = 1'b0;
    out_item_t         expected_hits [$];
    int                fails = 0;
    int                checked = 0;

    task automatic report(string field, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
        if (fails < 100)
            $display("mismatch on %s: got %h, expected %h", field, got, want);
        fails++;
    endtask

    // wider interval first on equal starts, new one after equal entries
    function automatic logic stays_ahead(logic [ADDR_W-1:0] s, logic [ADDR_W-1:0] z,
                                         logic [ADDR_W-1:0] ns, logic [ADDR_W-1:0] nz);
        return (s != ns) ? (s < ns) : (z >= nz);
    endfunction

    task automatic insert_interval(in_item_t it);
        int pos;
        if (it.is_function && it.interval_size != '0 && it.interval_start != '0
            && entry_total < TABLE_DEPTH)
        begin
            pos = entry_total;
            while (pos > 0 && !stays_ahead(start_tab[pos-1], size_tab[pos-1],
                                           it.interval_start, it.interval_size))
            begin
                start_tab[pos] = start_tab[pos-1];
                size_tab[pos] = size_tab[pos-1];
                pos--;
            end
            start_tab[pos] = it.interval_start;
            size_tab[pos] = it.interval_size;
            entry_total++;
        end
    endtask

    task automatic scan_byte(in_item_t it);
        out_item_t         hit;
        logic [ADDR_W-1:0] rel;
        int                lo;
        int                hi;
        int                mid;
        if (last_seen_ok && last_seen == PAIR_FIRST && it.code_byte == PAIR_SECOND)
        begin
            rel = stream_pos - 64'd1;
            hit = '0;
            hit.hit_address = base_address + rel;
            hit.hit_file_offset = file_offset + rel;
            lo = 0;
            hi = entry_total;
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (start_tab[mid] <= hit.hit_address)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            if (lo > 0 && hit.hit_address - start_tab[lo-1] < size_tab[lo-1])
            begin
                hit.covered = 1'b1;
                hit.cover_index = COVER_INDEX_W'(lo - 1);
                hit.cover_start = start_tab[lo-1];
                hit.cover_size = size_tab[lo-1];
            end
            expected_hits.push_back(hit);
        end
        if (it.last_byte)
        begin
            stream_pos = '0;
            last_seen = '0;
            last_seen_ok = 1'b0;
        end
        else
        begin
            stream_pos = stream_pos + 64'd1;
            last_seen = it.code_byte;
            last_seen_ok = 1'b1;
        end
    endtask

    task automatic compare_hit(out_item_t got);
        out_item_t want;
        if (expected_hits.size() == 0)
        begin
            report("unexpected result address", got.hit_address, '0);
        end
        else
        begin
            want = expected_hits.pop_front();
            if (got.hit_address !== want.hit_address)
                report("hit_address", got.hit_address, want.hit_address);
            if (got.hit_file_offset !== want.hit_file_offset)
                report("hit_file_offset", got.hit_file_offset, want.hit_file_offset);
            if (got.covered !== want.covered)
                report("covered", ADDR_W'(got.covered), ADDR_W'(want.covered));
            if (got.cover_index !== want.cover_index)
                report("cover_index", ADDR_W'(got.cover_index), ADDR_W'(want.cover_index));
            if (got.cover_start !== want.cover_start)
                report("cover_start", got.cover_start, want.cover_start);
            if (got.cover_size !== want.cover_size)
                report("cover_size", got.cover_size, want.cover_size);
        end
        checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address = '0;
            file_offset = '0;
            entry_total = 0;
            stream_pos = '0;
            last_seen = '0;
            last_seen_ok = 1'b0;
            expected_hits.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[PADDR_W-1:3] == REG_BASE_ADDRESS)
                    base_address = pwdata;
                else if (paddr[PADDR_W-1:3] == REG_FILE_OFFSET)
                    file_offset = pwdata;
            end
            if (in_valid && in_ready)
            begin
                if (in_data.op == OP_LOAD)
                    insert_interval(in_data);
                else
                    scan_byte(in_data);
            end
            if (out_valid && out_ready)
                compare_hit(out_data);
            pending <= expected_hits.size();
        end
        fail_count <= fails;
        result_count <= checked;
    end

endmodule

[test/tb.sv]
// stimulus and verdict for the opcode site locator: directed items and random phases
// under changing idle patterns; depends on osl_pkg, opcode_site_locator_unit and
// site_hit_checker
`timescale 1ns / 1ps
module tb;
    import osl_pkg::*;

    localparam int LIMIT = 1_000_000;
    localparam int SETTLE = 2 * TABLE_DEPTH + 40;
    localparam int PHASES = 7;
    localparam int PHASE_ITEMS = 120;
    localparam logic [ADDR_W-1:0] ALL_ONES = '1;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    in_item_t           in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    out_item_t          out_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [ADDR_W-1:0]  pwdata = '0;
    logic [ADDR_W-1:0]  prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;
    int                 result_count;

    idle_mode_t         idle_mode = IDLE_NONE;
    logic [ADDR_W-1:0]  cur_base = '0;
    logic [ADDR_W-1:0]  scan_pos = '0;
    int                 sent = 0;
    int                 settings = 0;

    opcode_site_locator_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    site_hit_checker hit_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .fail_count  (fail_count),
        .pending     (pending),
        .result_count(result_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (idle_mode == IDLE_RECEIVER)
            out_ready <= ($urandom_range(99) >= 69);
        else if (idle_mode == IDLE_BOTH)
            out_ready <= ($urandom_range(99) >= 9);
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    function automatic in_item_t load_item(logic [ADDR_W-1:0] s, logic [ADDR_W-1:0] z,
                                           logic f);
        in_item_t it;
        it.op = OP_LOAD;
        it.interval_start = s;
        it.interval_size = z;
        it.is_function = f;
        it.code_byte = 8'($urandom);
        it.last_byte = 1'($urandom);
        return it;
    endfunction

    function automatic in_item_t byte_item(logic [7:0] b, logic last);
        in_item_t it;
        it.op = OP_BYTE;
        it.interval_start = {$urandom, $urandom};
        it.interval_size = {$urandom, $urandom};
        it.is_function = 1'($urandom);
        it.code_byte = b;
        it.last_byte = last;
        return it;
    endfunction

    // loads land near the current scan address so that many hits are covered
    function automatic in_item_t random_item();
        int                pick;
        logic [ADDR_W-1:0] near;
        logic [ADDR_W-1:0] wide;
        logic [7:0]        b;
        pick = $urandom_range(99);
        near = cur_base + scan_pos + ADDR_W'($urandom_range(96)) - 64'd32;
        wide = {$urandom, $urandom};
        if (pick < 14)
            return load_item(near, ($urandom_range(7) == 0) ? wide
                                   : ADDR_W'($urandom_range(64, 1)), 1'b1);
        if (pick < 17)
        begin
            case ($urandom_range(3))
                0: return load_item(near, ADDR_W'($urandom_range(64, 1)), 1'b0);
                1: return load_item(near, '0, 1'b1);
                2: return load_item('0, ADDR_W'($urandom_range(64, 1)), 1'b1);
                default: return load_item(wide, {$urandom, $urandom}, 1'($urandom));
            endcase
        end
        pick = $urandom_range(99);
        b = (pick < 35) ? PAIR_FIRST : (pick < 70) ? PAIR_SECOND : 8'($urandom);
        return byte_item(b, $urandom_range(99) < 2);
    endfunction

    task automatic send_item(in_item_t it);
        int gap;
        gap = (idle_mode == IDLE_SENDER) ? 69 : (idle_mode == IDLE_BOTH) ? 9 : 0;
        while ($urandom_range(99) < gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
        if (it.op == OP_BYTE)
            scan_pos = it.last_byte ? '0 : scan_pos + 64'd1;
    endtask

    task automatic write_reg(logic idx, logic [ADDR_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // a load leaves no result behind, so wait out the longest insertion shift
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_section(logic [ADDR_W-1:0] b, logic [ADDR_W-1:0] o);
        drain();
        write_reg(REG_BASE_ADDRESS, b);
        write_reg(REG_FILE_OFFSET, o);
        cur_base = b;
        settings++;
    endtask

    initial
    begin
        logic [ADDR_W-1:0] b;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        b = 64'h0000_0000_0040_1000;
        set_section(b, 64'h0000_0000_0000_1000);
        // rejected loads: not a function, zero size, zero start
        send_item(load_item(b + 64'h10, 64'h20, 1'b0));
        send_item(load_item(b + 64'h10, '0, 1'b1));
        send_item(load_item('0, 64'h20, 1'b1));
        // equal starts: wider first, equal size after the existing one
        send_item(load_item(b + 64'h10, 64'h20, 1'b1));
        send_item(load_item(b + 64'h10, 64'h40, 1'b1));
        send_item(load_item(b + 64'h10, 64'h20, 1'b1));
        send_item(load_item(ALL_ONES, ALL_ONES, 1'b1));
        send_item(load_item(b + 64'h3, 64'h1, 1'b1));
        send_item(byte_item(PAIR_FIRST, 1'b0));
        send_item(byte_item(PAIR_SECOND, 1'b0));
        send_item(byte_item(PAIR_FIRST, 1'b0));
        send_item(byte_item(PAIR_FIRST, 1'b0));
        send_item(byte_item(PAIR_SECOND, 1'b0));
        send_item(byte_item(8'h00, 1'b0));
        send_item(byte_item(8'hFF, 1'b0));
        // section end splits a pair
        send_item(byte_item(PAIR_FIRST, 1'b1));
        send_item(byte_item(PAIR_SECOND, 1'b0));
        // pair completed on the last byte
        send_item(byte_item(PAIR_FIRST, 1'b0));
        send_item(byte_item(PAIR_SECOND, 1'b1));
        // address just past a one-byte interval
        repeat (4) send_item(byte_item(8'h90, 1'b0));
        send_item(byte_item(PAIR_FIRST, 1'b0));
        send_item(byte_item(PAIR_SECOND, 1'b0));

        for (int p = 0; p < PHASES; p++)
        begin
            idle_mode <= idle_mode_t'(p % 4);
            case (p)
                0: set_section('0, '0);
                1: set_section(ALL_ONES - 64'h80, ALL_ONES);
                default: set_section({$urandom, $urandom}, {$urandom, $urandom});
            endcase
            repeat (PHASE_ITEMS) send_item(random_item());
        end

        // pair at the top of the address space, against the all-ones interval
        idle_mode <= IDLE_BOTH;
        send_item(byte_item(8'h00, 1'b1));
        set_section(ALL_ONES, {$urandom, $urandom});
        send_item(byte_item(PAIR_FIRST, 1'b0));
        send_item(byte_item(PAIR_SECOND, 1'b0));
        repeat (100) send_item(random_item());

        drain();
        $display("sent %0d input transfers under %0d section register settings",
                 sent, settings);
        $display("compared %0d results over %0d random phases", result_count, PHASES);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
